/* rtl/three_region_stack_unit_assert.svh */
// Assertion macros for the three region stack unit.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef THREE_REGION_STACK_UNIT_ASSERT_SVH
`define THREE_REGION_STACK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define TSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define TSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TSU_ASSERT_SAME(label, ante, cons, msg)

`define TSU_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* rtl/tsu_pkg.sv */
`timescale 1ns / 1ps

package tsu_pkg;

    // Width of the length register and of the fill counters.
    localparam int LEN_W = 11;

    localparam int LEN_RESET = 1024;

    // floor(x / 3) for x below 2048 is (x * 2731) >> 13.
    localparam logic [12:0] RECIP_THIRD = 13'd2731;
    localparam int RECIP_SHIFT = 13;
    localparam int PROD_W = LEN_W + RECIP_SHIFT;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] SEL_FIRST  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_THIRD  = 2'd2;
    localparam logic [1:0] SEL_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic respond;
    } cmd_t;

endpackage

/* rtl/tsu_ram.sv */
`timescale 1ns / 1ps

module tsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tsu_ctrl.sv */
`timescale 1ns / 1ps

module tsu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output tsu_pkg::cmd_t cmd
);

    import tsu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        busy        = 1'b1;
        done        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.respond = 1'b1;
                done        = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tsu_datapath.sv */
`timescale 1ns / 1ps

module tsu_datapath #(
    parameter int STORE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsu_pkg::cmd_t                   cmd,
    input  logic                            cfg_we,
    input  logic [tsu_pkg::LEN_W-1:0]       cfg_wdata,
    input  logic                            operation,
    input  logic [1:0]                      stack_select,
    input  logic signed [31:0]              push_value,
    output logic signed [31:0]              pop_value,
    output logic [1:0]                      status
);

    import tsu_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LEN_RST_SAT = (LEN_RESET > STORE_DEPTH) ? STORE_DEPTH : LEN_RESET;
    localparam logic [LEN_W-1:0] LEN_RST   = LEN_W'(LEN_RST_SAT);
    localparam logic [LEN_W-1:0] THIRD_RST = LEN_W'(LEN_RST_SAT / 3);

    // Region geometry, refreshed on every length write.
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] third_reg;
    logic [LEN_W-1:0] len_sat;
    logic [PROD_W-1:0] third_prod;

    logic [LEN_W-1:0] cnt0_reg, cnt0_next;
    logic [LEN_W-1:0] cnt1_reg, cnt1_next;
    logic [LEN_W-1:0] cnt2_reg, cnt2_next;

    // Captured item.
    logic             op_reg;
    logic [1:0]       sel_reg;
    logic [31:0]      val_reg;

    logic [1:0]       status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;

    logic [LEN_W-1:0] cnt_cur;
    logic [LEN_W-1:0] cnt_dec;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] cap;
    logic [LEN_W-1:0] twice_third;
    logic [LEN_W-1:0] slot;
    logic             is_full;
    logic             is_empty;
    logic             do_push;
    logic             do_pop;

    logic                  ram_en;
    logic [ADDR_W-1:0]     ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign len_sat    = (32'(cfg_wdata) > 32'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : cfg_wdata;
    assign third_prod = PROD_W'(len_sat) * PROD_W'(RECIP_THIRD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= LEN_RST;
            third_reg <= THIRD_RST;
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
            cnt2_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg   <= len_sat;
                third_reg <= third_prod[PROD_W-1:RECIP_SHIFT];
            end
            cnt0_reg <= cnt0_next;
            cnt1_reg <= cnt1_next;
            cnt2_reg <= cnt2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            sel_reg <= stack_select;
            val_reg <= push_value;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    assign twice_third = LEN_W'({third_reg, 1'b0});
    assign cnt_dec     = cnt_cur - LEN_W'(1);

    always_comb
    begin
        cnt_cur = '0;
        base    = '0;
        cap     = '0;
        case (sel_reg)
            SEL_FIRST:
            begin
                cnt_cur = cnt0_reg;
                cap     = third_reg;
            end
            SEL_SECOND:
            begin
                cnt_cur = cnt1_reg;
                base    = third_reg;
                cap     = third_reg;
            end
            SEL_THIRD:
            begin
                cnt_cur = cnt2_reg;
                base    = twice_third;
                cap     = len_reg - twice_third;
            end
            default:
            begin
                // The unused selector acts as a stack that holds nothing.
                cnt_cur = '0;
            end
        endcase
    end

    assign is_full  = (sel_reg == SEL_UNUSED) || (cnt_cur >= cap);
    assign is_empty = (sel_reg == SEL_UNUSED) || (cnt_cur == '0);
    assign do_push  = cmd.exec && (op_reg == OP_PUSH) && !is_full;
    assign do_pop   = cmd.exec && (op_reg == OP_POP) && !is_empty;

    always_comb
    begin
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        if (op_reg == OP_PUSH)
        begin
            if (is_full)
            begin
                status_next = ST_FULL;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                pop_ok_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt0_next = cnt0_reg;
        cnt1_next = cnt1_reg;
        cnt2_next = cnt2_reg;
        if (cfg_we)
        begin
            cnt0_next = '0;
            cnt1_next = '0;
            cnt2_next = '0;
        end
        else if (do_push || do_pop)
        begin
            case (sel_reg)
                SEL_FIRST:  cnt0_next = do_push ? cnt_cur + LEN_W'(1) : cnt_dec;
                SEL_SECOND: cnt1_next = do_push ? cnt_cur + LEN_W'(1) : cnt_dec;
                SEL_THIRD:  cnt2_next = do_push ? cnt_cur + LEN_W'(1) : cnt_dec;
                default:    cnt2_next = cnt2_reg;
            endcase
        end
    end

    // A pop reads the slot below the old top; a push writes at the old top.
    assign slot      = base + (do_pop ? cnt_dec : cnt_cur);
    assign ram_en    = do_push || do_pop;
    assign ram_addr  = ADDR_W'(slot);
    assign ram_wdata = DATA_WIDTH'($unsigned(val_reg));

    tsu_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (do_push),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign pop_value = pop_ok_reg ? 32'($signed(ram_rdata)) : 32'sd0;
    assign status    = status_reg;

endmodule

/* rtl/three_region_stack_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         start, taken when !busy   operation, stack_select, push_value
// result    out        done, one-cycle strobe    pop_value, status
// config    in         array_length_we           array_length_wdata
//
// The done strobe is high in S_RESP, the result state, which follows the store access
// state S_EXEC; the registered read port of the store makes the result wait for it.
// A new item is accepted in the cycle after done, so items never overlap.
// Reset empties all three stacks and sets the length to 1024, saturated to STORE_DEPTH.
// The store itself is not cleared; there is no clearing pass after reset.
// The receiver cannot stall: each result beat is valid only while done is high.

module three_region_stack_unit #(
    parameter int STORE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      operation,
    input  logic [1:0]                stack_select,
    input  logic signed [31:0]        push_value,
    output logic                      done,
    output logic signed [31:0]        pop_value,
    output logic [1:0]                status,
    input  logic                      array_length_we,
    input  logic [tsu_pkg::LEN_W-1:0] array_length_wdata
);

    import tsu_pkg::*;

    `include "three_region_stack_unit_assert.svh"

    cmd_t cmd;

    tsu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    tsu_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (array_length_we),
        .cfg_wdata    (array_length_wdata),
        .operation    (operation),
        .stack_select (stack_select),
        .push_value   (push_value),
        .pop_value    (pop_value),
        .status       (status)
    );

    `TSU_ASSERT_SAME(a_done_while_busy, done, busy, "result strobe outside an item")
    `TSU_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy && !done, "item not held busy")
    `TSU_ASSERT_NEXT(a_done_frees, done, !busy && !done, "block not idle after result")
    `TSU_ASSERT_SAME(a_fail_zero, done && (status != ST_OK), pop_value == 32'sd0,
        "failed item returned data")

endmodule

/* test/three_region_stack_checker.sv */
`timescale 1ns / 1ps

module three_region_stack_checker #(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      operation,
    input  logic [1:0]                stack_select,
    input  logic signed [31:0]        push_value,
    input  logic                      done,
    input  logic signed [31:0]        pop_value,
    input  logic [1:0]                status,
    input  logic                      array_length_we,
    input  logic [tsu_pkg::LEN_W-1:0] array_length_wdata,
    output int                        fail_count,
    output int                        pending_count,
    output int                        results_checked
);

    import tsu_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         code;
    } stack_result_t;

    logic [31:0]     region_store [0:STORE_DEPTH-1];
    int              fill_level [0:2];
    logic [LEN_W-1:0] length_reg;
    stack_result_t   expected_results [$];
    stack_result_t   oldest;

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        results_checked = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Applies one command to the shadow stacks and returns the result it should give.
    function automatic stack_result_t predict_stack_op(input logic op, input logic [1:0] sel,
                                                       input logic [31:0] value);
        stack_result_t res;
        int len;
        int third;
        int base;
        int cap;

        len = (int'(length_reg) > STORE_DEPTH) ? STORE_DEPTH : int'(length_reg);
        third = len / 3;
        res.value = '0;
        res.code = ST_OK;
        if (sel == SEL_UNUSED)
        begin
            res.code = (op == OP_PUSH) ? ST_FULL : ST_EMPTY;
            return res;
        end
        base = int'(sel) * third;
        cap = (sel == SEL_THIRD) ? len - 2 * third : third;
        if (op == OP_PUSH)
        begin
            if (fill_level[sel] >= cap)
                res.code = ST_FULL;
            else
            begin
                region_store[base + fill_level[sel]] = value;
                fill_level[sel]++;
            end
        end
        else if (fill_level[sel] == 0)
            res.code = ST_EMPTY;
        else
        begin
            fill_level[sel]--;
            res.value = region_store[base + fill_level[sel]];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg = LEN_W'(LEN_RESET);
            fill_level = '{0, 0, 0};
            expected_results.delete();
            pending_count = 0;
        end
        else
        begin
            // Check the result beat before queuing a new command so that the order holds
            // even if both land on the same edge.
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result beat with nothing outstanding", pop_value,
                                    32'(status));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (pop_value !== oldest.value)
                        report_mismatch("pop_value", pop_value, oldest.value);
                    if (status !== oldest.code)
                        report_mismatch("status", 32'(status), 32'(oldest.code));
                    results_checked++;
                end
            end
            if (array_length_we)
            begin
                length_reg = array_length_wdata;
                fill_level = '{0, 0, 0};
            end
            if (start && !busy)
                expected_results.insert(expected_results.size(),
                                        predict_stack_op(operation, stack_select,
                                                         push_value));
            pending_count = expected_results.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tsu_pkg::*;

    localparam int STALL_LIMIT = 400;
    localparam int PHASE_ITEMS = 85;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               operation;
    logic [1:0]         stack_select;
    logic signed [31:0] push_value;
    logic               done;
    logic signed [31:0] pop_value;
    logic [1:0]         status;
    logic               array_length_we;
    logic [LEN_W-1:0]   array_length_wdata;

    int fail_count;
    int pending_count;
    int results_checked;
    int items_sent;
    int lengths_written;
    int idle_pct;
    int stall_cycles;

    logic [LEN_W-1:0] phase_lengths [0:11] = '{11'd1, 11'd2, 11'd4, 11'd5, 11'd7, 11'd1025,
                                               11'd9, 11'd3, 11'd6, 11'd12, 11'd33, 11'd1024};

    three_region_stack_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .stack_select(stack_select),
        .push_value(push_value),
        .done(done),
        .pop_value(pop_value),
        .status(status),
        .array_length_we(array_length_we),
        .array_length_wdata(array_length_wdata)
    );

    three_region_stack_checker stack_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .stack_select(stack_select),
        .push_value(push_value),
        .done(done),
        .pop_value(pop_value),
        .status(status),
        .array_length_we(array_length_we),
        .array_length_wdata(array_length_wdata),
        .fail_count(fail_count),
        .pending_count(pending_count),
        .results_checked(results_checked)
    );

    always #4 clk = ~clk;

    // Start stays high from one command to the next unless the sender decides to idle.
    task automatic send_command(input logic op, input logic [1:0] sel, input logic [31:0] value);
        start <= 1'b1;
        operation <= op;
        stack_select <= sel;
        push_value <= value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        @(posedge clk);
        array_length_we <= 1'b1;
        array_length_wdata <= len;
        @(posedge clk);
        array_length_we <= 1'b0;
        lengths_written++;
    endtask

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int phase;
        int sent_in_phase;
        int burst_kind;
        int burst_len;
        int k;
        logic op;
        logic [1:0] sel;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_PUSH;
        stack_select = SEL_FIRST;
        push_value = '0;
        array_length_we = 1'b0;
        array_length_wdata = '0;
        items_sent = 0;
        lengths_written = 0;
        idle_pct = 38;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset length: empty pops, the unused selector, extreme values coming back LIFO.
        send_command(OP_POP, SEL_FIRST, 32'h0);
        send_command(OP_POP, SEL_UNUSED, 32'h0);
        send_command(OP_PUSH, SEL_UNUSED, 32'h1234_5678);
        send_command(OP_PUSH, SEL_FIRST, 32'h8000_0000);
        send_command(OP_PUSH, SEL_FIRST, 32'h7FFF_FFFF);
        send_command(OP_PUSH, SEL_SECOND, 32'hFFFF_FFFF);
        send_command(OP_PUSH, SEL_THIRD, 32'h0000_0000);
        send_command(OP_PUSH, SEL_THIRD, 32'h5A5A_5A5A);
        send_command(OP_POP, SEL_FIRST, 32'hFFFF_FFFF);
        send_command(OP_POP, SEL_FIRST, 32'h0);
        send_command(OP_POP, SEL_FIRST, 32'h0);
        send_command(OP_POP, SEL_SECOND, 32'h0);
        send_command(OP_POP, SEL_THIRD, 32'h0);
        send_command(OP_POP, SEL_THIRD, 32'h0);
        send_command(OP_POP, SEL_THIRD, 32'h0);

        // Length 3 gives each stack a single entry.
        write_length(11'd3);
        send_command(OP_PUSH, SEL_FIRST, 32'hA5A5_A5A5);
        send_command(OP_PUSH, SEL_FIRST, 32'h0000_0001);
        send_command(OP_PUSH, SEL_SECOND, 32'hC3C3_C3C3);
        send_command(OP_PUSH, SEL_THIRD, 32'h3C3C_3C3C);
        send_command(OP_PUSH, SEL_THIRD, 32'h0000_0002);
        send_command(OP_POP, SEL_SECOND, 32'h0);
        send_command(OP_POP, SEL_SECOND, 32'h0);

        // Length 0: the rewrite empties everything and no stack has room.
        write_length(11'd0);
        send_command(OP_POP, SEL_THIRD, 32'h0);
        send_command(OP_PUSH, SEL_THIRD, 32'h0000_0003);
        send_command(OP_PUSH, SEL_FIRST, 32'h0000_0004);

        // All-ones length saturates to the full store; fill the middle region past its top.
        write_length(11'd2047);
        for (k = 0; k < 342; k++)
            send_command(OP_PUSH, SEL_SECOND, $urandom);
        for (k = 0; k < 342; k++)
            send_command(OP_POP, SEL_SECOND, $urandom);

        for (phase = 0; phase < 12; phase++)
        begin
            if (phase == 4)
                idle_pct = 73;
            else if (phase == 8)
                idle_pct = 0;
            write_length(phase_lengths[phase]);
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS)
            begin
                burst_kind = $urandom_range(0, 2);
                burst_len = $urandom_range(1, 12);
                sel = ($urandom_range(0, 9) == 9) ? SEL_UNUSED : 2'($urandom_range(0, 2));
                for (k = 0; k < burst_len; k++)
                begin
                    if (burst_kind == 2)
                        op = 1'($urandom_range(0, 1));
                    else
                        op = (burst_kind == 1) ? OP_POP : OP_PUSH;
                    send_command(op, sel, $urandom);
                    sent_in_phase++;
                end
            end
        end

        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d commands across %0d length settings, from 0 up to 2047,",
                 items_sent, lengths_written);
        $display("under three sender idle profiles; %0d result beats checked, %0d mismatches.",
                 results_checked, fail_count);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
